/* rtl/assert_macros.svh */
// assertion macros shared by the rtl
// depends on nothing; taken in by modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/bmh_pkg.sv */
// shared types and constants of the binary min-heap
// no dependencies; used by bmh_ctrl, bmh_dp and binary_min_heap
package bmh_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 8;
  localparam int COUNT_W  = 5;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHD_W    = IDX_W + 2;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [CHD_W-1:0]   chd_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_POP    = 1'b1
  } bmh_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } bmh_status_e;

  typedef struct packed {
    bmh_op_e cmd;
    key_t    key;
  } bmh_in_t;

  typedef struct packed {
    key_t        popped_key;
    bmh_status_e status;
    count_t      count;
  } bmh_out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;    // take a new command beat
    logic rd_up;     // read parent of hole
    logic up_step;   // move parent down into hole
    logic rd_ends;   // read root and last slot
    logic load_ends; // capture root and last key
    logic rd_dn;     // read both children of hole
    logic dn_step;   // move smaller child up into hole
    logic place;     // write held key into hole
  } bmh_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic up_move;
    logic has_child;
    logic dn_move;
  } bmh_stat_t;

endpackage

/* rtl/bmh_ctrl.sv */
// sequencing state machine of the binary min-heap
// depends on bmh_pkg; drives bmh_dp through bmh_ctl_t
module bmh_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  bmh_pkg::bmh_op_e    op_i,
  input  bmh_pkg::bmh_stat_t  stat_i,
  output bmh_pkg::bmh_ctl_t   ctl_o,
  output logic                busy_o,
  output logic                done_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_UP_RD  = 8'b0000_0010,
    S_UP_CMP = 8'b0000_0100,
    S_POP_RD = 8'b0000_1000,
    S_POP_LD = 8'b0001_0000,
    S_DN_RD  = 8'b0010_0000,
    S_DN_CMP = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl_o.accept = 1'b1;
          if (op_i == bmh_pkg::CMD_INSERT) begin
            state_d = stat_i.full ? S_DONE : S_UP_RD;
          end else begin
            state_d = stat_i.empty ? S_DONE : S_POP_RD;
          end
        end
      end
      S_UP_RD: begin
        if (stat_i.at_root) begin
          ctl_o.place = 1'b1;
          state_d     = S_DONE;
        end else begin
          ctl_o.rd_up = 1'b1;
          state_d     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat_i.up_move) begin
          ctl_o.up_step = 1'b1;
          state_d       = S_UP_RD;
        end else begin
          ctl_o.place = 1'b1;
          state_d     = S_DONE;
        end
      end
      S_POP_RD: begin
        ctl_o.rd_ends = 1'b1;
        state_d       = S_POP_LD;
      end
      S_POP_LD: begin
        ctl_o.load_ends = 1'b1;
        state_d         = S_DN_RD;
      end
      S_DN_RD: begin
        if (!stat_i.has_child) begin
          ctl_o.place = 1'b1;
          state_d     = S_DONE;
        end else begin
          ctl_o.rd_dn = 1'b1;
          state_d     = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (stat_i.dn_move) begin
          ctl_o.dn_step = 1'b1;
          state_d       = S_DN_RD;
        end else begin
          ctl_o.place = 1'b1;
          state_d     = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

/* rtl/bmh_dp.sv */
// datapath of the binary min-heap: key memory, hole index, count, result regs
// depends on bmh_pkg; controlled by bmh_ctrl
module bmh_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bmh_pkg::bmh_ctl_t  ctl_i,
  input  bmh_pkg::bmh_in_t   in_i,
  output bmh_pkg::bmh_stat_t stat_o,
  output bmh_pkg::bmh_out_t  res_o
);

  bmh_pkg::key_t        mem_q [bmh_pkg::CAPACITY];
  bmh_pkg::cnt_t        cnt_q;
  bmh_pkg::idx_t        hole_q;
  bmh_pkg::key_t        key_q;
  bmh_pkg::key_t        popped_q;
  bmh_pkg::bmh_status_e status_q;
  bmh_pkg::key_t        rd0_q, rd1_q;

  bmh_pkg::idx_t parent_idx;
  bmh_pkg::chd_t left_idx, right_idx, cnt_ext;
  logic          has_right, right_smaller;
  bmh_pkg::idx_t kid_idx;
  bmh_pkg::key_t kid_val;
  bmh_pkg::idx_t rd_addr0, rd_addr1, wr_addr;
  bmh_pkg::key_t wr_data;
  logic          rd_en, wr_en;

  always_comb begin
    parent_idx    = (hole_q - bmh_pkg::idx_t'(1)) >> 1;
    left_idx      = {1'b0, hole_q, 1'b1};
    right_idx     = left_idx + bmh_pkg::chd_t'(1);
    cnt_ext       = bmh_pkg::chd_t'(cnt_q);
    has_right     = (right_idx < cnt_ext);
    // ties go to the left child
    right_smaller = has_right && (rd1_q < rd0_q);
    kid_idx       = right_smaller ? right_idx[bmh_pkg::IDX_W-1:0]
                                  : left_idx[bmh_pkg::IDX_W-1:0];
    kid_val       = right_smaller ? rd1_q : rd0_q;

    stat_o.full      = (cnt_q == bmh_pkg::cnt_t'(bmh_pkg::CAPACITY));
    stat_o.empty     = (cnt_q == '0);
    stat_o.at_root   = (hole_q == '0);
    stat_o.up_move   = (key_q < rd0_q);
    stat_o.has_child = (left_idx < cnt_ext);
    stat_o.dn_move   = (key_q > kid_val);

    rd_en    = ctl_i.rd_up | ctl_i.rd_ends | ctl_i.rd_dn;
    rd_addr0 = ctl_i.rd_up   ? parent_idx :
               ctl_i.rd_ends ? '0         : left_idx[bmh_pkg::IDX_W-1:0];
    rd_addr1 = ctl_i.rd_ends ? cnt_q[bmh_pkg::IDX_W-1:0]
                             : right_idx[bmh_pkg::IDX_W-1:0];

    wr_en   = ctl_i.place | ctl_i.up_step | ctl_i.dn_step;
    wr_addr = hole_q;
    wr_data = ctl_i.up_step ? rd0_q :
              ctl_i.dn_step ? kid_val : key_q;
  end

  // key memory, one write port and two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd0_q <= mem_q[rd_addr0];
      rd1_q <= mem_q[rd_addr1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctl_i.accept) begin
      if (in_i.cmd == bmh_pkg::CMD_INSERT) begin
        if (!stat_o.full) begin
          cnt_q <= cnt_q + bmh_pkg::cnt_t'(1);
        end
      end else if (!stat_o.empty) begin
        cnt_q <= cnt_q - bmh_pkg::cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      popped_q <= '0;
      key_q    <= in_i.key;
      if (in_i.cmd == bmh_pkg::CMD_INSERT) begin
        hole_q   <= cnt_q[bmh_pkg::IDX_W-1:0];
        status_q <= stat_o.full ? bmh_pkg::ST_FULL : bmh_pkg::ST_OK;
      end else begin
        hole_q   <= '0;
        status_q <= stat_o.empty ? bmh_pkg::ST_EMPTY : bmh_pkg::ST_OK;
      end
    end
    if (ctl_i.load_ends) begin
      popped_q <= rd0_q;
      key_q    <= rd1_q;
    end
    if (ctl_i.up_step) begin
      hole_q <= parent_idx;
    end
    if (ctl_i.dn_step) begin
      hole_q <= kid_idx;
    end
  end

  assign res_o.popped_key = popped_q;
  assign res_o.status     = status_q;
  assign res_o.count      = bmh_pkg::count_t'(cnt_q);

endmodule

/* rtl/binary_min_heap.sv */
// top level of the binary min-heap priority queue
// depends on bmh_pkg, bmh_ctrl, bmh_dp and assert_macros.svh
//
//  channel   | ports                      | beat taken when
//  ----------+----------------------------+---------------------------------
//  command   | start_i, busy_o, in_i      | start_i high while busy_o low
//  result    | done_o, out_o              | done_o high, one cycle, no stall
//
// an error beat (insert when full, pop when empty) goes from start straight
// to the done_o cycle; a good insert climbs the key up to 4 levels, then
// places it in the hole; a good pop reads and loads the root and last key,
// then sinks the moved key up to 3 levels for 16 slots and places it.
// each level is a registered memory read followed by a compare and a write
// back into the hole.
// busy_o drops the cycle after done_o, and the next command beat is taken then.
// reset clears the state machine and the key count; the key slots are not
// cleared, and a read may reach a slot past the last key, whose key is never used.
module binary_min_heap (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  bmh_pkg::bmh_in_t  in_i,
  output logic              busy_o,
  output logic              done_o,
  output bmh_pkg::bmh_out_t out_o
);

  `include "assert_macros.svh"

  bmh_pkg::bmh_ctl_t  ctl;
  bmh_pkg::bmh_stat_t stat;

  // sequencer: walks the sift one level at a time, a read state then a compare state
  bmh_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .op_i   (in_i.cmd),
    .stat_i (stat),
    .ctl_o  (ctl),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  // key slots, hole pointer, count and result registers
  bmh_dp u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl),
    .in_i  (in_i),
    .stat_o(stat),
    .res_o (out_o)
  );

  // terms of the result checks below
  logic refused_full, refused_empty;
  logic cnt_at_cap, nothing_left;

  assign refused_full  = done_o && (out_o.status == bmh_pkg::ST_FULL);
  assign refused_empty = done_o && (out_o.status == bmh_pkg::ST_EMPTY);
  assign cnt_at_cap    = (out_o.count == bmh_pkg::count_t'(bmh_pkg::CAPACITY));
  assign nothing_left  = (out_o.count == '0) && (out_o.popped_key == '0);

  // a result beat only comes out of a running command, then the block frees
  `ASSERT_IMPLIES(a_done_busy, clk_i, rst_ni, done_o, busy_o)
  `ASSERT_NEXT(a_done_idle, clk_i, rst_ni, done_o, !busy_o)
  // refused insert reports a full heap
  `ASSERT_IMPLIES(a_full_cnt, clk_i, rst_ni, refused_full, cnt_at_cap)
  // refused pop reports an empty heap and no key
  `ASSERT_IMPLIES(a_empty_cnt, clk_i, rst_ni, refused_empty, nothing_left)

endmodule
